### rtl/core/tft_pkg.sv
// Shared types, constants and codes for the transfer function table.
package tft_pkg;

    localparam int MaxPoints = 64;
    localparam int IdxBits   = 6;
    localparam int CntBits   = 7;
    localparam int PosBits   = 16;
    localparam int OpaBits   = 16;
    localparam int RgbBits   = 24;
    localparam int EntryBits = PosBits + OpaBits + RgbBits;

    localparam logic [2:0] OP_EVAL    = 3'd0;
    localparam logic [2:0] OP_INSERT  = 3'd1;
    localparam logic [2:0] OP_REMOVE  = 3'd2;
    localparam logic [2:0] OP_MOVE    = 3'd3;
    localparam logic [2:0] OP_RECOLOR = 3'd4;
    localparam logic [2:0] OP_FIND    = 3'd5;
    localparam logic [2:0] OP_LOAD    = 3'd6;
    localparam logic [2:0] OP_COUNT   = 3'd7;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_OUTSIDE  = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_REJECT   = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    localparam logic [0:0] REG_TOL_X = 1'd0;
    localparam logic [0:0] REG_TOL_Y = 1'd1;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [6:0]  entry_index;
        logic [15:0] position_x;
        logic [15:0] position_y;
        logic [7:0]  in_red;
        logic [7:0]  in_green;
        logic [7:0]  in_blue;
    } req_t;

    typedef struct packed {
        logic [7:0]  out_red;
        logic [7:0]  out_green;
        logic [7:0]  out_blue;
        logic [15:0] out_opacity;
        logic [5:0]  found_index;
        logic [2:0]  status;
    } rsp_t;

    typedef struct packed {
        logic [0:0]  index;
        logic [15:0] data;
    } cfg_t;

    // Divider control
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [15:0] quotient;
    } div_rsp_t;

endpackage

### rtl/core/tft_if.sv
// Valid/ready channel interfaces.
interface tft_req_if;
    logic            valid;
    logic            ready;
    tft_pkg::req_t   payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface tft_rsp_if;
    logic            valid;
    logic            ready;
    tft_pkg::rsp_t   payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface tft_cfg_if;
    logic            valid;
    logic            ready;
    tft_pkg::cfg_t   payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/tft_div.sv
// Restoring divider, one quotient bit per cycle.
module tft_div (
    input  logic              clk,
    input  logic              rst_n,
    input  tft_pkg::div_req_t req,
    output tft_pkg::div_rsp_t rsp
);
    logic [31:0] quo_reg, quo_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] dsr_reg, dsr_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] shifted;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[15:0], quo_reg[31]};
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, dsr_reg})
            begin
                rem_next = shifted - {1'b0, dsr_reg};
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg[15:0];
endmodule

### rtl/core/transfer_function_table.sv
// Transfer function table: control point store, sequencer and shared divider.
// Each item is taken, worked on alone, and answered with one result beat. The
// points sit in one 64-entry memory (x, opacity, colour) with one read and one
// write port; every scan reads the entries one after another. Evaluate scans
// for the segment, then runs four divisions on the one shared divider for red,
// green, blue and opacity; insert scans, runs three divisions and shifts up;
// remove shifts down; find scans; move, recolor, load and set count need no
// scan. A new beat is taken once the previous result has been handed over.
// Find compares against the tolerance registers at index 0 (x) and 1 (opacity);
// the user must write them only while idle, which the block does not enforce.
module transfer_function_table (
    input logic      clk,
    input logic      rst_n,
    tft_req_if.sink   in_ch,
    tft_rsp_if.source out_ch,
    tft_cfg_if.sink   cfg
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SRD   = 4'd1;  // scan: issue read of entry i
    localparam logic [3:0] S_SCHK  = 4'd2;  // scan: compare
    localparam logic [3:0] S_DIV   = 4'd3;  // start division for channel
    localparam logic [3:0] S_DWAIT = 4'd4;
    localparam logic [3:0] S_SHRD  = 4'd5;  // shift: read
    localparam logic [3:0] S_SHWR  = 4'd6;  // shift: write
    localparam logic [3:0] S_MVRD  = 4'd7;  // move, recolor: read entry, neighbours
    localparam logic [3:0] S_MVCHK = 4'd8;
    localparam logic [3:0] S_WRITE = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [tft_pkg::EntryBits-1:0] mem [tft_pkg::MaxPoints];
    logic [tft_pkg::EntryBits-1:0] rdata_reg;
    logic [tft_pkg::IdxBits-1:0]   raddr, waddr;
    logic [tft_pkg::EntryBits-1:0] wdata;
    logic                          we;

    logic [3:0]  state_reg, state_next;
    logic [6:0]  count_reg, count_next;
    logic [15:0] tolx_reg, toly_reg;
    tft_pkg::req_t req_reg, req_next;
    tft_pkg::rsp_t rsp_reg, rsp_next;
    logic [6:0]  ptr_reg, ptr_next;       // scan pointer
    logic [tft_pkg::EntryBits-1:0] prev_reg, prev_next, cur_reg, cur_next;
    logic [1:0]  ch_reg, ch_next;         // 0 r,1 g,2 b,3 opacity
    logic [2:0]  sub_reg, sub_next;       // move sub-step, division bypass flag
    logic [15:0] lo_reg, lo_next;
    logic [23:0] col_reg, col_next;

    tft_pkg::div_req_t dreq;
    tft_pkg::div_rsp_t drsp;

    tft_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    // entry fields
    logic [15:0] px_prev, px_cur, op_prev, op_cur, num, den;
    logic [15:0] ca, cb;
    logic [31:0] prod_a, prod_b, dividend;

    assign px_prev = prev_reg[55:40];
    assign px_cur  = cur_reg[55:40];
    assign op_prev = prev_reg[39:24];
    assign op_cur  = cur_reg[39:24];
    assign num     = req_reg.position_x - px_prev;
    assign den     = px_cur - px_prev;

    always_comb
    begin
        case (ch_reg)
            2'd0:    begin ca = {8'd0, prev_reg[23:16]}; cb = {8'd0, cur_reg[23:16]}; end
            2'd1:    begin ca = {8'd0, prev_reg[15:8]};  cb = {8'd0, cur_reg[15:8]};  end
            2'd2:    begin ca = {8'd0, prev_reg[7:0]};   cb = {8'd0, cur_reg[7:0]};   end
            default: begin ca = op_prev;                 cb = op_cur;                 end
        endcase
    end

    // a*(den-num) + b*num + den/2 fits 32 bits: it is at most max(a,b)*den + den/2
    assign prod_a   = ca * (den - num);
    assign prod_b   = cb * num;
    assign dividend = prod_a + prod_b + {17'd0, den[15:1]};

    // configuration
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolx_reg <= 16'd655;
            toly_reg <= 16'd655;
        end
        else if (cfg.valid)
        begin
            if (cfg.payload.index == tft_pkg::REG_TOL_X)
                tolx_reg <= cfg.payload.data;
            else
                toly_reg <= cfg.payload.data;
        end
    end

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign out_ch.valid = (state_reg == S_OUT);
    assign out_ch.payload = rsp_reg;

    // distances of the entry just read from the searched point
    logic [15:0] dx, dy, ex, ey;
    assign ex = rdata_reg[55:40];
    assign ey = rdata_reg[39:24];
    assign dx = (ex >= req_reg.position_x) ? ex - req_reg.position_x : req_reg.position_x - ex;
    assign dy = (ey >= req_reg.position_y) ? ey - req_reg.position_y : req_reg.position_y - ey;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        req_next   = req_reg;
        rsp_next   = rsp_reg;
        ptr_next   = ptr_reg;
        prev_next  = prev_reg;
        cur_next   = cur_reg;
        ch_next    = ch_reg;
        sub_next   = sub_reg;
        lo_next    = lo_reg;
        col_next   = col_reg;
        raddr      = ptr_reg[5:0];
        waddr      = ptr_reg[5:0];
        wdata      = rdata_reg;
        we         = 1'b0;
        dreq.start    = 1'b0;
        dreq.dividend = dividend;
        dreq.divisor  = den;
        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    req_next = in_ch.payload;
                    rsp_next = '0;
                    case (in_ch.payload.opcode)
                        tft_pkg::OP_EVAL, tft_pkg::OP_INSERT:
                        begin
                            if (in_ch.payload.opcode == tft_pkg::OP_INSERT &&
                                count_reg >= 7'(tft_pkg::MaxPoints))
                            begin
                                rsp_next.status = tft_pkg::ST_FULL;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                ptr_next = 7'd0;
                                state_next = S_SRD;
                            end
                        end
                        tft_pkg::OP_REMOVE:
                        begin
                            if (in_ch.payload.entry_index > 7'd0 &&
                                {1'b0, in_ch.payload.entry_index} + 8'd1 < {1'b0, count_reg})
                            begin
                                ptr_next = in_ch.payload.entry_index;
                                state_next = S_SHRD;
                            end
                            else
                            begin
                                rsp_next.status = tft_pkg::ST_REJECT;
                                state_next = S_OUT;
                            end
                        end
                        tft_pkg::OP_MOVE:
                        begin
                            if (in_ch.payload.entry_index >= count_reg)
                            begin
                                rsp_next.status = tft_pkg::ST_REJECT;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                ptr_next = in_ch.payload.entry_index;
                                sub_next = 3'd0;
                                state_next = S_MVRD;
                            end
                        end
                        tft_pkg::OP_RECOLOR:
                        begin
                            if (in_ch.payload.entry_index >= count_reg)
                            begin
                                rsp_next.status = tft_pkg::ST_REJECT;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                ptr_next = in_ch.payload.entry_index;
                                sub_next = 3'd0;
                                state_next = S_MVRD;
                            end
                        end
                        tft_pkg::OP_FIND:
                        begin
                            ptr_next = 7'd0;
                            state_next = S_SRD;
                        end
                        tft_pkg::OP_LOAD:
                        begin
                            if (in_ch.payload.entry_index >= 7'(tft_pkg::MaxPoints))
                                rsp_next.status = tft_pkg::ST_REJECT;
                            else
                            begin
                                we    = 1'b1;
                                waddr = in_ch.payload.entry_index[5:0];
                                wdata = {in_ch.payload.position_x, in_ch.payload.position_y,
                                         in_ch.payload.in_red, in_ch.payload.in_green,
                                         in_ch.payload.in_blue};
                            end
                            state_next = S_OUT;
                        end
                        default:
                        begin
                            if (in_ch.payload.entry_index <= 7'(tft_pkg::MaxPoints))
                                count_next = in_ch.payload.entry_index;
                            else
                                rsp_next.status = tft_pkg::ST_REJECT;
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_SRD:
            begin
                // read issued at ptr; data valid next cycle
                if (ptr_reg >= count_reg)
                begin
                    rsp_next.status = (req_reg.opcode == tft_pkg::OP_FIND) ?
                                      tft_pkg::ST_NOTFOUND : tft_pkg::ST_OUTSIDE;
                    state_next = S_OUT;
                end
                else
                    state_next = S_SCHK;
            end
            S_SCHK:
            begin
                prev_next = rdata_reg;
                cur_next  = rdata_reg;
                ptr_next  = ptr_reg + 7'd1;
                state_next = S_SRD;
                if (req_reg.opcode == tft_pkg::OP_FIND)
                begin
                    if (dx <= tolx_reg && dy <= toly_reg)
                    begin
                        rsp_next.found_index = ptr_reg[5:0];
                        state_next = S_OUT;
                    end
                end
                else if (ptr_reg != 7'd0 &&
                         req_reg.position_x >= px_cur &&
                         req_reg.position_x <= rdata_reg[55:40])
                begin
                    // segment ptr-1..ptr; prev holds entry ptr-1
                    prev_next = cur_reg;
                    ptr_next  = ptr_reg;
                    ch_next   = 2'd0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (den == 16'd0)
                begin
                    case (ch_reg)
                        2'd0:    col_next[23:16] = ca[7:0];
                        2'd1:    col_next[15:8]  = ca[7:0];
                        2'd2:    col_next[7:0]   = ca[7:0];
                        default: lo_next = ca;
                    endcase
                    sub_next = 3'd1;
                end
                else
                begin
                    dreq.start = 1'b1;
                    sub_next = 3'd0;
                end
                state_next = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (sub_reg == 3'd1 || drsp.done)
                begin
                    if (sub_reg != 3'd1)
                    begin
                        case (ch_reg)
                            2'd0:    col_next[23:16] = drsp.quotient[7:0];
                            2'd1:    col_next[15:8]  = drsp.quotient[7:0];
                            2'd2:    col_next[7:0]   = drsp.quotient[7:0];
                            default: lo_next = drsp.quotient;
                        endcase
                    end
                    if ((req_reg.opcode == tft_pkg::OP_EVAL && ch_reg == 2'd3) ||
                        (req_reg.opcode == tft_pkg::OP_INSERT && ch_reg == 2'd2))
                    begin
                        if (req_reg.opcode == tft_pkg::OP_EVAL)
                        begin
                            rsp_next.out_red     = col_next[23:16];
                            rsp_next.out_green   = col_next[15:8];
                            rsp_next.out_blue    = col_next[7:0];
                            rsp_next.out_opacity = lo_next;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            rsp_next.found_index = ptr_reg[5:0];
                            lo_next  = {9'd0, ptr_reg};  // insert position
                            ptr_next = count_reg;
                            state_next = S_SHRD;
                        end
                    end
                    else
                    begin
                        ch_next = ch_reg + 2'd1;
                        state_next = S_DIV;
                    end
                end
            end
            S_SHRD:
            begin
                // insert moves entry ptr-1 to ptr; remove moves ptr+1 to ptr
                if (req_reg.opcode == tft_pkg::OP_INSERT)
                begin
                    if (ptr_reg == lo_reg[6:0])
                    begin
                        we = 1'b1;
                        wdata = {req_reg.position_x, req_reg.position_y, col_reg};
                        count_next = count_reg + 7'd1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        raddr = 6'(ptr_reg - 7'd1);
                        state_next = S_SHWR;
                    end
                end
                else
                begin
                    if (ptr_reg + 7'd1 >= count_reg)
                    begin
                        count_next = count_reg - 7'd1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        raddr = 6'(ptr_reg + 7'd1);
                        state_next = S_SHWR;
                    end
                end
            end
            S_SHWR:
            begin
                we = 1'b1;
                if (req_reg.opcode == tft_pkg::OP_INSERT)
                    ptr_next = ptr_reg - 7'd1;
                else
                    ptr_next = ptr_reg + 7'd1;
                state_next = S_SHRD;
            end
            S_MVRD:
            begin
                // sub 0 read own, 1 read left, 2 read right, then write
                case (sub_reg)
                    3'd0:    raddr = ptr_reg[5:0];
                    3'd1:    raddr = 6'(ptr_reg - 7'd1);
                    default: raddr = 6'(ptr_reg + 7'd1);
                endcase
                state_next = S_MVCHK;
            end
            S_MVCHK:
            begin
                state_next = S_MVRD;
                sub_next = sub_reg + 3'd1;
                case (sub_reg)
                    3'd0:
                    begin
                        cur_next = rdata_reg;
                        if (req_reg.opcode == tft_pkg::OP_RECOLOR)
                        begin
                            cur_next[23:0] = {req_reg.in_red, req_reg.in_green,
                                              req_reg.in_blue};
                            state_next = S_WRITE;
                        end
                        else if (ptr_reg == 7'd0 || ptr_reg + 7'd1 >= count_reg)
                        begin
                            cur_next[39:24] = req_reg.position_y;
                            state_next = S_WRITE;
                        end
                        else
                        begin
                            cur_next[55:24] = {req_reg.position_x, req_reg.position_y};
                        end
                    end
                    3'd1:
                    begin
                        if (cur_reg[55:40] < rdata_reg[55:40])
                            cur_next[55:40] = rdata_reg[55:40];
                    end
                    default:
                    begin
                        if (cur_reg[55:40] > rdata_reg[55:40])
                            cur_next[55:40] = rdata_reg[55:40];
                        state_next = S_WRITE;
                    end
                endcase
            end
            S_WRITE:
            begin
                we = 1'b1;
                wdata = cur_reg;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ch.ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // memory with one write port and one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        rsp_reg  <= rsp_next;
        ptr_reg  <= ptr_next;
        prev_reg <= prev_next;
        cur_reg  <= cur_next;
        ch_reg   <= ch_next;
        sub_reg  <= sub_next;
        lo_reg   <= lo_next;
        col_reg  <= col_next;
    end
endmodule
